// ===== hdl/assert_macros.svh =====
// assertion helpers for the plotter checkers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only while the block is out of reset
`define ASSERT_RUN(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// property checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// ===== hdl/mpp_pkg.sv =====
`timescale 1ns / 1ps

package mpp_pkg;

    localparam int MAX_WIDTH   = 128;
    localparam int MAX_HEIGHT  = 64;
    localparam int MAX_STRIDE  = (MAX_WIDTH + 7) / 8;
    localparam int STORE_DEPTH = MAX_STRIDE * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int DIM_W       = 9;
    localparam int STRIDE_W    = $clog2(MAX_STRIDE + 1);
    localparam int OFS_W       = STRIDE_W + 8;

    localparam logic [7:0] RST_WIDTH  = 8'd128;
    localparam logic [6:0] RST_HEIGHT = 7'd64;

    typedef enum logic [1:0] {
        MODE_JUMP = 2'd0,
        MODE_STEP = 2'd1,
        MODE_PLOT = 2'd2,
        MODE_READ = 2'd3
    } t_mode;

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_reg;

endpackage

// ===== hdl/mono_pixel_pen_plotter_top.sv =====
`timescale 1ns / 1ps

// channel   | dir | data (lsb first)                                           | user
// ----------+-----+------------------------------------------------------------+-----
// s_axis    | in  | jump_x 8, jump_y 8, step_axis 1, step_dir 2, pen_ink 1,    | mode
//           |     | read_index 10, 2 zero bits                                  |
// m_axis    | out | in_bounds 1, read_byte 8, cur_x 8, cur_y 8, 7 zero bits     | -
// cfg write | in  | i_cfg_index 0 pixel_width, 1 pixel_height, i_cfg_data       | -
//
// jump, step and a plot outside the area in use are answered from the transfer;
// a plot inside the area and a read first pass S_MOD or S_READ, as the store
// read is registered: the byte is read, then modified and written back
// reset is synchronous; after it the store is swept to zero, one byte a cycle,
// over all STORE_DEPTH (1024) bytes, during which no transfer is taken on s_axis
// a result sits in the output register until taken; the next item is taken in
// the same cycle that result leaves

module mono_pixel_pen_plotter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // jump_x[7:0], jump_y[15:8], step_axis[16], step_dir[18:17], pen_ink[19],
    // read_index[29:20], zero[31:30]
    input  logic [31:0] s_axis_tdata,
    // mode[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // in_bounds[0], read_byte[8:1], cur_x[16:9], cur_y[24:17], zero[31:25]
    output logic [31:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_MOD   = 4'b0100,
        S_READ  = 4'b1000
    } t_state;

    // state and configuration
    t_state r_state, n_state;
    logic [7:0] r_pixel_width;
    logic [6:0] r_pixel_height;
    logic [7:0] r_pen_col, n_pen_col;
    logic [7:0] r_pen_row, n_pen_row;

    // frame store, one write and one registered read per cycle
    logic [7:0] r_store [mpp_pkg::STORE_DEPTH];
    logic [7:0] r_rdata;
    logic [mpp_pkg::ADDR_W-1:0] r_clr_addr;
    logic [mpp_pkg::ADDR_W-1:0] r_addr;
    logic [mpp_pkg::ADDR_W-1:0] rd_addr;
    logic [mpp_pkg::ADDR_W-1:0] wr_addr;
    logic [7:0] wr_data;
    logic       wr_en;

    // pending plot
    logic [7:0] r_mask;
    logic       r_ink;
    logic       r_rd_ok;

    // output register
    logic       r_out_valid;
    logic       r_out_bounds;
    logic [7:0] r_out_byte;
    logic [7:0] r_out_x;
    logic [7:0] r_out_y;

    // decoded input fields
    mpp_pkg::t_mode in_mode;
    logic [7:0] in_jump_x;
    logic [7:0] in_jump_y;
    logic       in_step_axis;
    logic [1:0] in_step_dir;
    logic       in_pen_ink;
    logic [9:0] in_read_index;

    logic in_xfer;
    logic [7:0] delta;
    logic [mpp_pkg::DIM_W-1:0] used_w;
    logic [mpp_pkg::DIM_W-1:0] used_h;
    logic [mpp_pkg::STRIDE_W-1:0] stride;
    logic [mpp_pkg::OFS_W-1:0] offset;
    logic cur_inside;
    logic next_inside;
    logic plot_ok;
    logic read_ok;

    assign in_mode       = mpp_pkg::t_mode'(s_axis_tuser);
    assign in_jump_x     = s_axis_tdata[7:0];
    assign in_jump_y     = s_axis_tdata[15:8];
    assign in_step_axis  = s_axis_tdata[16];
    assign in_step_dir   = s_axis_tdata[18:17];
    assign in_pen_ink    = s_axis_tdata[19];
    assign in_read_index = s_axis_tdata[29:20];

    // input taken only between items and when the output slot frees up
    assign s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || m_axis_tready);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_y, r_out_x, r_out_byte, r_out_bounds};

    // width and height in use, clamped to the store geometry
    always_comb begin
        if ({1'b0, r_pixel_width} > mpp_pkg::DIM_W'(mpp_pkg::MAX_WIDTH)) begin
            used_w = mpp_pkg::DIM_W'(mpp_pkg::MAX_WIDTH);
        end else begin
            used_w = {1'b0, r_pixel_width};
        end
        if ({2'b00, r_pixel_height} > mpp_pkg::DIM_W'(mpp_pkg::MAX_HEIGHT)) begin
            used_h = mpp_pkg::DIM_W'(mpp_pkg::MAX_HEIGHT);
        end else begin
            used_h = {2'b00, r_pixel_height};
        end
    end

    // row stride in bytes and byte offset under the pen
    assign stride = mpp_pkg::STRIDE_W'((used_w + mpp_pkg::DIM_W'(7)) >> 3);
    assign offset = mpp_pkg::OFS_W'(stride) * mpp_pkg::OFS_W'(r_pen_row)
                  + mpp_pkg::OFS_W'(r_pen_col >> 3);

    assign cur_inside  = ({1'b0, r_pen_col} < used_w) && ({1'b0, r_pen_row} < used_h);
    assign next_inside = ({1'b0, n_pen_col} < used_w) && ({1'b0, n_pen_row} < used_h);
    assign plot_ok     = cur_inside && (offset < mpp_pkg::OFS_W'(mpp_pkg::STORE_DEPTH));
    assign read_ok     = ({1'b0, in_read_index} < 11'(mpp_pkg::STORE_DEPTH));

    // +1 for code one, -1 for both negative codes
    always_comb begin
        if (in_step_dir == 2'b01) begin
            delta = 8'h01;
        end else if (in_step_dir[1]) begin
            delta = 8'hFF;
        end else begin
            delta = 8'h00;
        end
    end

    // next pen position
    always_comb begin
        n_pen_col = r_pen_col;
        n_pen_row = r_pen_row;
        if (in_xfer) begin
            case (in_mode)
                mpp_pkg::MODE_JUMP: begin
                    n_pen_col = in_jump_x;
                    n_pen_row = in_jump_y;
                end
                mpp_pkg::MODE_STEP: begin
                    if (in_step_axis) begin
                        n_pen_row = r_pen_row + delta;
                    end else begin
                        n_pen_col = r_pen_col + delta;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == mpp_pkg::ADDR_W'(mpp_pkg::STORE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_xfer && in_mode == mpp_pkg::MODE_PLOT && plot_ok) begin
                    n_state = S_MOD;
                end else if (in_xfer && in_mode == mpp_pkg::MODE_READ) begin
                    n_state = S_READ;
                end
            end
            S_MOD:   n_state = S_IDLE;
            S_READ:  n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    // store port selection: plot offset or read index to read, sweep or write-back of a plot to write
    assign rd_addr = (in_mode == mpp_pkg::MODE_PLOT) ? offset[mpp_pkg::ADDR_W-1:0]
                                                     : in_read_index[mpp_pkg::ADDR_W-1:0];
    assign wr_en   = (r_state == S_CLEAR) || (r_state == S_MOD);
    assign wr_addr = (r_state == S_CLEAR) ? r_clr_addr : r_addr;
    assign wr_data = (r_state == S_CLEAR) ? 8'h00
                   : (r_ink ? (r_rdata | r_mask) : (r_rdata & ~r_mask));

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[wr_addr] <= wr_data;
        end
        r_rdata <= r_store[rd_addr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_clr_addr     <= '0;
            r_pen_col      <= 8'd0;
            r_pen_row      <= 8'd0;
            r_pixel_width  <= mpp_pkg::RST_WIDTH;
            r_pixel_height <= mpp_pkg::RST_HEIGHT;
            r_out_valid    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pen_col <= n_pen_col;
            r_pen_row <= n_pen_row;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cfg_we) begin
                unique case (mpp_pkg::t_reg'(i_cfg_index))
                    mpp_pkg::REG_WIDTH:  r_pixel_width  <= i_cfg_data;
                    mpp_pkg::REG_HEIGHT: r_pixel_height <= i_cfg_data[6:0];
                    default: begin
                    end
                endcase
            end
            // result valid at once for jump, step and a plot that misses
            if (in_xfer) begin
                r_out_valid <= !((in_mode == mpp_pkg::MODE_PLOT && plot_ok)
                                 || in_mode == mpp_pkg::MODE_READ);
            end else if (r_state == S_MOD || r_state == S_READ) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload of the pending plot and of the result
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_addr       <= offset[mpp_pkg::ADDR_W-1:0];
            r_mask       <= 8'h01 << r_pen_col[2:0];
            r_ink        <= in_pen_ink;
            r_rd_ok      <= read_ok;
            r_out_bounds <= next_inside;
            r_out_byte   <= 8'h00;
            r_out_x      <= n_pen_col;
            r_out_y      <= n_pen_row;
        end else if (r_state == S_READ) begin
            r_out_byte <= r_rd_ok ? r_rdata : 8'h00;
        end
    end

endmodule

// ===== hdl/mpp_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mpp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [31:0] s_axis_tdata,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // a stalled result holds
    `ASSERT_RUN(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

    // the frame sweep after reset blocks input
    `ASSERT_ALWAYS(a_rst_block, i_clk, !i_rst_n |=> !s_axis_tready)

    // input is only taken when the output slot is free or draining
    `ASSERT_RUN(a_ready_slot, i_clk, i_rst_n, s_axis_tready |-> !m_axis_tvalid || m_axis_tready)

    // a jump answers in the next cycle with the new pen and no read data
    `ASSERT_RUN(a_jump_result, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && s_axis_tuser == mpp_pkg::MODE_JUMP |=> m_axis_tvalid && m_axis_tdata[16:9] == $past(s_axis_tdata[7:0]) && m_axis_tdata[24:17] == $past(s_axis_tdata[15:8]) && m_axis_tdata[8:1] == 8'h00)

endmodule

bind mono_pixel_pen_plotter_top mpp_checker u_mpp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/mono_pixel_pen_plotter_top_tb.sv =====
`timescale 1ns / 1ps

module mono_pixel_pen_plotter_top_tb;

    // step direction codes as they travel in step_dir
    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_POS  = 2'd1;
    localparam logic [1:0] DIR_NEG2 = 2'd2;
    localparam logic [1:0] DIR_NEG  = 2'd3;
    localparam logic AXIS_COL  = 1'b0;
    localparam logic AXIS_ROW  = 1'b1;
    localparam logic INK_CLEAR = 1'b0;
    localparam logic INK_SET   = 1'b1;

    // cycles with no transfer before the run is called hung; covers the
    // store sweep after reset plus the longest stalls
    localparam int STALL_LIMIT   = 8000;
    // settle time before register writes
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 125;

    // register settings walked by the random phases, extremes first
    localparam logic [7:0] PHASE_W [8] = '{8'd128, 8'd1, 8'd255, 8'd0,
                                           8'd128, 8'd8, 8'd100, 8'd13};
    localparam logic [6:0] PHASE_H [8] = '{7'd64, 7'd1, 7'd127, 7'd64,
                                           7'd0, 7'd8, 7'd50, 7'd37};

    typedef struct {
        mpp_pkg::t_mode mode;
        logic [7:0]     jump_x;
        logic [7:0]     jump_y;
        logic           step_axis;
        logic [1:0]     step_dir;
        logic           pen_ink;
        logic [9:0]     read_index;
    } t_pen_cmd;

    typedef struct {
        logic       in_bounds;
        logic [7:0] read_byte;
        logic [7:0] cur_x;
        logic [7:0] cur_y;
    } t_pen_status;

    // one row of the directed table: either a register update or a command
    typedef struct {
        bit          is_dims;
        bit          checked;
        t_pen_cmd    cmd;
        t_pen_status want;
        logic [7:0]  width;
        logic [6:0]  height;
    } t_step_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [7:0]  i_cfg_data;

    // shadow copy of the plotter state
    logic [7:0] frame_bytes [mpp_pkg::STORE_DEPTH];
    logic [7:0] pen_x;
    logic [7:0] pen_y;
    logic [7:0] width_reg;
    logic [6:0] height_reg;

    t_pen_status awaited_status [$];
    int          mismatch_count = 0;
    int          quiet_cycles = 0;
    bit          steady;

    mono_pixel_pen_plotter_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // width and height in use, clamped to the store geometry
    function automatic int used_w();
        return (width_reg > mpp_pkg::MAX_WIDTH) ? mpp_pkg::MAX_WIDTH : int'(width_reg);
    endfunction

    function automatic int used_h();
        return (height_reg > mpp_pkg::MAX_HEIGHT) ? mpp_pkg::MAX_HEIGHT : int'(height_reg);
    endfunction

    function automatic bit pen_inside();
        return (pen_x < used_w()) && (pen_y < used_h());
    endfunction

    // moves the shadow pen / store for one command and returns its status
    function automatic t_pen_status apply_pen_cmd(t_pen_cmd c);
        t_pen_status s;
        logic [7:0]  delta;
        logic [7:0]  mask;
        int          stride;
        int          ofs;
        s.read_byte = 8'd0;
        case (c.mode)
            mpp_pkg::MODE_JUMP: begin
                pen_x = c.jump_x;
                pen_y = c.jump_y;
            end
            mpp_pkg::MODE_STEP: begin
                // both negative codes step back by one
                delta = (c.step_dir == DIR_POS)  ? 8'h01 :
                        (c.step_dir == DIR_NONE) ? 8'h00 : 8'hFF;
                if (c.step_axis == AXIS_ROW) pen_y = pen_y + delta;
                else                         pen_x = pen_x + delta;
            end
            mpp_pkg::MODE_PLOT: begin
                if (pen_inside()) begin
                    stride = (used_w() + 7) / 8;
                    ofs    = stride * int'(pen_y) + int'(pen_x) / 8;
                    mask   = 8'h01 << pen_x[2:0];
                    if (ofs < mpp_pkg::STORE_DEPTH) begin
                        if (c.pen_ink == INK_SET) frame_bytes[ofs] = frame_bytes[ofs] | mask;
                        else                      frame_bytes[ofs] = frame_bytes[ofs] & ~mask;
                    end
                end
            end
            mpp_pkg::MODE_READ: begin
                if (c.read_index < mpp_pkg::STORE_DEPTH)
                    s.read_byte = frame_bytes[c.read_index];
            end
            default: ;
        endcase
        s.in_bounds = pen_inside();
        s.cur_x     = pen_x;
        s.cur_y     = pen_y;
        return s;
    endfunction

    function automatic t_pen_cmd pen_cmd(mpp_pkg::t_mode m, logic [7:0] jx, logic [7:0] jy,
                                         logic axis, logic [1:0] dir, logic ink,
                                         logic [9:0] ridx);
        t_pen_cmd c;
        c.mode       = m;
        c.jump_x     = jx;
        c.jump_y     = jy;
        c.step_axis  = axis;
        c.step_dir   = dir;
        c.pen_ink    = ink;
        c.read_index = ridx;
        return c;
    endfunction

    // command row checked against the shadow model
    function automatic t_step_row probe(t_pen_cmd c);
        t_step_row r;
        r.is_dims = 1'b0;
        r.checked = 1'b0;
        r.cmd     = c;
        r.want    = '{1'b0, 8'd0, 8'd0, 8'd0};
        r.width   = 8'd0;
        r.height  = 7'd0;
        return r;
    endfunction

    // command row with its status typed in
    function automatic t_step_row probe_want(t_pen_cmd c, logic ib, logic [7:0] rb,
                                             logic [7:0] x, logic [7:0] y);
        t_step_row r;
        r         = probe(c);
        r.checked = 1'b1;
        r.want    = '{ib, rb, x, y};
        return r;
    endfunction

    function automatic t_step_row dims_row(logic [7:0] w, logic [6:0] h);
        t_step_row r;
        r         = probe(pen_cmd(mpp_pkg::MODE_JUMP, 8'd0, 8'd0, AXIS_COL, DIR_NONE,
                                  INK_CLEAR, 10'd0));
        r.is_dims = 1'b1;
        r.width   = w;
        r.height  = h;
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) return 0;
        if (r < 90)           return $urandom_range(1, 3);
        if (r < 98)           return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // random command, biased toward positions and bytes inside the area in use
    function automatic t_pen_cmd random_cmd();
        t_pen_cmd c;
        int       r;
        int       region;
        r = $urandom_range(0, 99);
        c = pen_cmd(mpp_pkg::MODE_JUMP, 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                    1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)));
        if (r < 20)      c.mode = mpp_pkg::MODE_JUMP;
        else if (r < 50) c.mode = mpp_pkg::MODE_STEP;
        else if (r < 80) c.mode = mpp_pkg::MODE_PLOT;
        else             c.mode = mpp_pkg::MODE_READ;
        if (c.mode == mpp_pkg::MODE_JUMP) begin
            if (used_w() > 0 && $urandom_range(0, 99) < 75)
                c.jump_x = 8'($urandom_range(0, used_w() - 1));
            if (used_h() > 0 && $urandom_range(0, 99) < 75)
                c.jump_y = 8'($urandom_range(0, used_h() - 1));
        end
        region = ((used_w() + 7) / 8) * used_h();
        if (c.mode == mpp_pkg::MODE_READ && region > 0 && $urandom_range(0, 99) < 70)
            c.read_index = 10'($urandom_range(0, region - 1));
        return c;
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        $display("mismatch %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // offer one command, wait for its transfer, then queue the awaited status
    task automatic drive_cmd(t_pen_cmd c, bit checked, t_pen_status want);
        int          gap;
        t_pen_status s;
        gap = idle_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, c.read_index, c.pen_ink, c.step_dir, c.step_axis,
                          c.jump_y, c.jump_x};
        s_axis_tuser  <= c.mode;
        do @(posedge i_clk); while (!s_axis_tready);
        s = apply_pen_cmd(c);
        awaited_status.push_back(checked ? want : s);
    endtask

    // sender holds off until every awaited status is back
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (awaited_status.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_dims(logic [7:0] w, logic [6:0] h);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= mpp_pkg::REG_WIDTH;
        i_cfg_data  <= w;
        @(posedge i_clk);
        i_cfg_index <= mpp_pkg::REG_HEIGHT;
        i_cfg_data  <= {1'b0, h};
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        width_reg  = w;
        height_reg = h;
    endtask

    // result side: pop the oldest awaited status on every transfer
    always @(posedge i_clk) begin
        t_pen_status want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (awaited_status.size() == 0) begin
                flag_mismatch("unexpected result", int'(m_axis_tdata), 0);
            end else begin
                want = awaited_status.pop_front();
                if (m_axis_tdata[0] !== want.in_bounds)
                    flag_mismatch("in_bounds", int'(m_axis_tdata[0]), int'(want.in_bounds));
                if (m_axis_tdata[8:1] !== want.read_byte)
                    flag_mismatch("read_byte", int'(m_axis_tdata[8:1]), int'(want.read_byte));
                if (m_axis_tdata[16:9] !== want.cur_x)
                    flag_mismatch("cur_x", int'(m_axis_tdata[16:9]), int'(want.cur_x));
                if (m_axis_tdata[24:17] !== want.cur_y)
                    flag_mismatch("cur_y", int'(m_axis_tdata[24:17]), int'(want.cur_y));
            end
        end
    end

    // hang detector: cycles in a row with no transfer on either stream
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("mono_pixel_pen_plotter_top_tb failed");
            $finish;
        end
    end

    // result side backpressure: random stalls between runs of ready
    initial begin
        int stall;
        int run;
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            stall = idle_len();
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            run = $urandom_range(1, 24);
            repeat (run) @(posedge i_clk);
        end
    end

    initial begin
        t_step_row   directed [$];
        t_pen_status no_want;
        logic [7:0]  w;
        logic [6:0]  h;

        // every input known from time zero, while reset is held
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= mpp_pkg::MODE_JUMP;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= mpp_pkg::REG_WIDTH;
        i_cfg_data    <= '0;
        steady         = 1'b0;
        no_want        = '{1'b0, 8'd0, 8'd0, 8'd0};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // shadow state after reset: clear store, pen at origin, full area
        foreach (frame_bytes[i]) frame_bytes[i] = 8'd0;
        pen_x      = 8'd0;
        pen_y      = 8'd0;
        width_reg  = mpp_pkg::RST_WIDTH;
        height_reg = mpp_pkg::RST_HEIGHT;

        // directed part: extremes, wrap, every mode and step code, clamping
        directed.push_back(probe_want(pen_cmd(mpp_pkg::MODE_READ, 8'd0, 8'd0, AXIS_COL,
                           DIR_NONE, INK_CLEAR, 10'd0), 1'b1, 8'd0, 8'd0, 8'd0));
        // far corner: out of bounds, plot there leaves the store alone
        directed.push_back(probe_want(pen_cmd(mpp_pkg::MODE_JUMP, 8'd255, 8'd255, AXIS_COL,
                           DIR_NONE, INK_CLEAR, 10'd0), 1'b0, 8'd0, 8'd255, 8'd255));
        directed.push_back(probe_want(pen_cmd(mpp_pkg::MODE_PLOT, 8'd0, 8'd0, AXIS_COL,
                           DIR_NONE, INK_SET, 10'd0), 1'b0, 8'd0, 8'd255, 8'd255));
        // wrap on both axes
        directed.push_back(probe_want(pen_cmd(mpp_pkg::MODE_STEP, 8'd0, 8'd0, AXIS_COL,
                           DIR_POS, INK_CLEAR, 10'd0), 1'b0, 8'd0, 8'd0, 8'd255));
        directed.push_back(probe_want(pen_cmd(mpp_pkg::MODE_STEP, 8'd0, 8'd0, AXIS_ROW,
                           DIR_POS, INK_CLEAR, 10'd0), 1'b1, 8'd0, 8'd0, 8'd0));
        directed.push_back(probe_want(pen_cmd(mpp_pkg::MODE_STEP, 8'd0, 8'd0, AXIS_COL,
                           DIR_NEG, INK_CLEAR, 10'd0), 1'b0, 8'd0, 8'd255, 8'd0));
        // minus two counts as a plain negative step
        directed.push_back(probe_want(pen_cmd(mpp_pkg::MODE_STEP, 8'd0, 8'd0, AXIS_COL,
                           DIR_NEG2, INK_CLEAR, 10'd0), 1'b0, 8'd0, 8'd254, 8'd0));
        directed.push_back(probe_want(pen_cmd(mpp_pkg::MODE_STEP, 8'd0, 8'd0, AXIS_ROW,
                           DIR_NONE, INK_CLEAR, 10'd0), 1'b0, 8'd0, 8'd254, 8'd0));
        // last pixel of the store lands in bit 7 of the last byte
        directed.push_back(probe_want(pen_cmd(mpp_pkg::MODE_JUMP, 8'd127, 8'd63, AXIS_COL,
                           DIR_NONE, INK_CLEAR, 10'd0), 1'b1, 8'd0, 8'd127, 8'd63));
        directed.push_back(probe_want(pen_cmd(mpp_pkg::MODE_PLOT, 8'd0, 8'd0, AXIS_COL,
                           DIR_NONE, INK_SET, 10'd0), 1'b1, 8'd0, 8'd127, 8'd63));
        directed.push_back(probe_want(pen_cmd(mpp_pkg::MODE_READ, 8'd0, 8'd0, AXIS_COL,
                           DIR_NONE, INK_CLEAR, 10'd1023), 1'b1, 8'h80, 8'd127, 8'd63));
        // one past the edge on each axis
        directed.push_back(probe_want(pen_cmd(mpp_pkg::MODE_JUMP, 8'd128, 8'd63, AXIS_COL,
                           DIR_NONE, INK_CLEAR, 10'd0), 1'b0, 8'd0, 8'd128, 8'd63));
        directed.push_back(probe_want(pen_cmd(mpp_pkg::MODE_JUMP, 8'd0, 8'd64, AXIS_COL,
                           DIR_NONE, INK_CLEAR, 10'd0), 1'b0, 8'd0, 8'd0, 8'd64));
        directed.push_back(probe_want(pen_cmd(mpp_pkg::MODE_STEP, 8'd0, 8'd0, AXIS_ROW,
                           DIR_NEG, INK_CLEAR, 10'd0), 1'b1, 8'd0, 8'd0, 8'd63));
        // set then clear bit 0 of the first byte of the last row
        directed.push_back(probe(pen_cmd(mpp_pkg::MODE_PLOT, 8'd0, 8'd0, AXIS_COL, DIR_NONE,
                           INK_SET, 10'd0)));
        directed.push_back(probe_want(pen_cmd(mpp_pkg::MODE_READ, 8'd0, 8'd0, AXIS_COL,
                           DIR_NONE, INK_CLEAR, 10'd1008), 1'b1, 8'h01, 8'd0, 8'd63));
        directed.push_back(probe(pen_cmd(mpp_pkg::MODE_PLOT, 8'd0, 8'd0, AXIS_COL, DIR_NONE,
                           INK_CLEAR, 10'd0)));
        directed.push_back(probe(pen_cmd(mpp_pkg::MODE_READ, 8'd0, 8'd0, AXIS_COL, DIR_NONE,
                           INK_CLEAR, 10'd1008)));
        // zero width: nothing is in bounds, plot is dropped
        directed.push_back(dims_row(8'd0, 7'd64));
        directed.push_back(probe_want(pen_cmd(mpp_pkg::MODE_JUMP, 8'd0, 8'd0, AXIS_COL,
                           DIR_NONE, INK_CLEAR, 10'd0), 1'b0, 8'd0, 8'd0, 8'd0));
        directed.push_back(probe(pen_cmd(mpp_pkg::MODE_PLOT, 8'd0, 8'd0, AXIS_COL, DIR_NONE,
                           INK_SET, 10'd0)));
        directed.push_back(probe(pen_cmd(mpp_pkg::MODE_READ, 8'd0, 8'd0, AXIS_COL, DIR_NONE,
                           INK_CLEAR, 10'd0)));
        // registers above the store size clamp to it
        directed.push_back(dims_row(8'd255, 7'd127));
        directed.push_back(probe_want(pen_cmd(mpp_pkg::MODE_JUMP, 8'd127, 8'd63, AXIS_COL,
                           DIR_NONE, INK_CLEAR, 10'd0), 1'b1, 8'd0, 8'd127, 8'd63));
        // narrow area: stride of two bytes
        directed.push_back(dims_row(8'd9, 7'd1));
        directed.push_back(probe(pen_cmd(mpp_pkg::MODE_JUMP, 8'd8, 8'd0, AXIS_COL, DIR_NONE,
                           INK_CLEAR, 10'd0)));
        directed.push_back(probe(pen_cmd(mpp_pkg::MODE_PLOT, 8'd0, 8'd0, AXIS_COL, DIR_NONE,
                           INK_SET, 10'd0)));
        directed.push_back(probe(pen_cmd(mpp_pkg::MODE_READ, 8'd0, 8'd0, AXIS_COL, DIR_NONE,
                           INK_CLEAR, 10'd1)));

        foreach (directed[i]) begin
            if (directed[i].is_dims) begin
                hold_until_drained();
                write_dims(directed[i].width, directed[i].height);
            end else begin
                drive_cmd(directed[i].cmd, directed[i].checked, directed[i].want);
            end
        end

        // random phases, one register setting each; every third runs without gaps
        for (int p = 0; p < PHASES; p++) begin
            hold_until_drained();
            if (p < 8) begin
                w = PHASE_W[p];
                h = PHASE_H[p];
            end else begin
                w = 8'($urandom_range(1, 255));
                h = 7'($urandom_range(1, 127));
            end
            steady = (p % 3 == 2);
            write_dims(w, h);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // mid-phase hold-off: let the result side catch up completely
                if (k == PHASE_ITEMS / 2) hold_until_drained();
                drive_cmd(random_cmd(), 1'b0, no_want);
            end
        end

        // wind down: everything back, then a short tail for stray results
        s_axis_tvalid <= 1'b0;
        steady = 1'b0;
        do @(posedge i_clk); while (awaited_status.size() != 0);
        repeat (SETTLE_CYCLES * 4) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("mono_pixel_pen_plotter_top_tb passed");
        else
            $display("mono_pixel_pen_plotter_top_tb failed");
        $finish;
    end

endmodule
